### hw/rtl/llrs_pkg.sv
// ============================================================================
// llrs_pkg: shared types and constants for the replica selector
// Payload structs, command classes, opcodes, status codes and back-end states.
// ============================================================================
package llrs_pkg;

  localparam int unsigned NODES_DEF     = 16;
  localparam int unsigned NODE_W        = 4;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned REPLICAS      = 3;
  localparam int unsigned Q_DEPTH       = 2;
  localparam logic [CNT_W-1:0] SAT_VAL       = 16'hFFFF;
  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd1500;

  localparam logic [2:0] OP_PLACE     = 3'd0;
  localparam logic [2:0] OP_FAILOVER  = 3'd1;
  localparam logic [2:0] OP_RECOVER   = 3'd2;
  localparam logic [2:0] OP_HEARTBEAT = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_NO_LIVE = 2'd2;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [NODE_W-1:0] node;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] replica_first;
    logic [NODE_W-1:0] replica_second;
    logic [NODE_W-1:0] replica_third;
  } out_t;

  typedef enum logic [2:0] {
    K_PLACE,
    K_FAIL,
    K_RECOVER,
    K_HEART,
    K_TICK,
    K_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [NODE_W-1:0] node;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PSCAN,
    BK_PINC,
    BK_TSCAN
  } bk_state_t;

endpackage

### hw/rtl/llrs_front.sv
// ============================================================================
// llrs_front: command intake and classification
// Accepts a command when the queue has room and turns it into a command
// class, rejecting bad node numbers and unknown opcodes up front.
// ============================================================================
module llrs_front #(
  parameter int unsigned NODES = llrs_pkg::NODES_DEF
) (
  input  logic              start,
  input  llrs_pkg::in_t     in_data,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output llrs_pkg::cmd_t    cmd
);

  logic node_ok;

  assign busy    = q_full;
  assign push    = start && !q_full;
  assign node_ok = (in_data.node != '0) && (32'(in_data.node) < NODES);

  always_comb begin
    cmd.node = in_data.node;
    unique case (in_data.opcode)
      llrs_pkg::OP_PLACE:     cmd.kind = llrs_pkg::K_PLACE;
      llrs_pkg::OP_FAILOVER:  cmd.kind = node_ok ? llrs_pkg::K_FAIL : llrs_pkg::K_REJECT;
      llrs_pkg::OP_RECOVER:   cmd.kind = node_ok ? llrs_pkg::K_RECOVER : llrs_pkg::K_REJECT;
      llrs_pkg::OP_HEARTBEAT: cmd.kind = node_ok ? llrs_pkg::K_HEART : llrs_pkg::K_REJECT;
      llrs_pkg::OP_TICK:      cmd.kind = llrs_pkg::K_TICK;
      default:                cmd.kind = llrs_pkg::K_REJECT;
    endcase
  end

endmodule

### hw/rtl/llrs_fifo.sv
// ============================================================================
// llrs_fifo: command queue between front and back
// Small register queue of classified commands; head is shown combinationally.
// ============================================================================
module llrs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  llrs_pkg::cmd_t din,
  input  logic           pop,
  output llrs_pkg::cmd_t dout,
  output logic           full,
  output logic           empty
);

  localparam int unsigned DEPTH = llrs_pkg::Q_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  llrs_pkg::cmd_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### hw/rtl/llrs_back.sv
// ============================================================================
// llrs_back: command execution engine
// Holds node state, scans the load and age memories for place and tick,
// applies single-node commands at dispatch and drives the result strobe.
// ============================================================================
module llrs_back #(
  parameter int unsigned NODES = llrs_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  llrs_pkg::cmd_t              q_head,
  output logic                        q_pop,
  input  logic                        cfg_valid,
  input  logic [llrs_pkg::CNT_W-1:0]  cfg_data,
  output logic                        out_valid,
  output llrs_pkg::out_t              out_data
);

  localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW    = llrs_pkg::CNT_W;
  localparam int unsigned RP    = llrs_pkg::REPLICAS;
  localparam int unsigned KW    = $clog2(RP);
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(NODES - 1);
  localparam logic [IDX_W-1:0] FIRST = IDX_W'(1);

  llrs_pkg::bk_state_t state_r, state_nxt;

  logic [CW-1:0]    load_mem [NODES];
  logic [CW-1:0]    age_mem  [NODES];

  logic [NODES-1:0] failed_r, failed_nxt;
  logic [NODES-1:0] heard_r, heard_nxt;
  logic [NODES-1:0] lvld_r, lvld_nxt;
  logic [NODES-1:0] avld_r, avld_nxt;

  logic [CW-1:0]    timeout_r;

  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             issued_r, issued_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] pidx_r;
  logic [CW-1:0]    load_rd_r, age_rd_r;
  logic             lvq_r, avq_r;

  logic [RP-1:0]    bh_r, bh_nxt;
  logic [IDX_W-1:0] bi_r [RP];
  logic [IDX_W-1:0] bi_nxt [RP];
  logic [CW-1:0]    bv_r [RP];
  logic [CW-1:0]    bv_nxt [RP];
  logic [KW-1:0]    k_r, k_nxt;

  logic             out_valid_r, out_valid_nxt;
  llrs_pkg::out_t   out_r, out_nxt;

  logic             lwe, awe;
  logic [IDX_W-1:0] lwaddr, awaddr;
  logic [CW-1:0]    lwdata, awdata;
  logic             issue;
  logic [IDX_W-1:0] n;
  logic [CW-1:0]    lval, aval, nage;
  logic [RP-1:0]    lt;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign n         = IDX_W'(q_head.node);
  assign lval      = lvq_r ? load_rd_r : '0;
  assign aval      = avq_r ? age_rd_r : '0;
  assign nage      = (aval == llrs_pkg::SAT_VAL) ? aval : aval + 1'b1;

  always_comb begin
    for (int k = 0; k < RP; k++) begin
      lt[k] = !bh_r[k] || (lval < bv_r[k]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    failed_nxt    = failed_r;
    heard_nxt     = heard_r;
    lvld_nxt      = lvld_r;
    avld_nxt      = avld_r;
    addr_nxt      = addr_r;
    issued_nxt    = issued_r;
    bh_nxt        = bh_r;
    bi_nxt        = bi_r;
    bv_nxt        = bv_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    issue         = 1'b0;
    lwe           = 1'b0;
    lwaddr        = bi_r[k_r];
    lwdata        = (bv_r[k_r] == llrs_pkg::SAT_VAL) ? bv_r[k_r] : bv_r[k_r] + 1'b1;
    awe           = 1'b0;
    awaddr        = pidx_r;
    awdata        = nage;

    unique case (state_r)
      llrs_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          out_nxt = '0;
          unique case (q_head.kind)
            llrs_pkg::K_PLACE: begin
              state_nxt  = llrs_pkg::BK_PSCAN;
              addr_nxt   = FIRST;
              issued_nxt = 1'b0;
              bh_nxt     = '0;
            end
            llrs_pkg::K_TICK: begin
              state_nxt  = llrs_pkg::BK_TSCAN;
              addr_nxt   = FIRST;
              issued_nxt = 1'b0;
            end
            llrs_pkg::K_FAIL: begin
              out_valid_nxt = 1'b1;
              if (failed_r[n]) begin
                out_nxt.status = llrs_pkg::ST_REJECT;
              end else begin
                failed_nxt[n] = 1'b1;
                lvld_nxt[n]   = 1'b0;
              end
            end
            llrs_pkg::K_RECOVER: begin
              out_valid_nxt = 1'b1;
              if (!failed_r[n]) begin
                out_nxt.status = llrs_pkg::ST_REJECT;
              end else begin
                failed_nxt[n] = 1'b0;
              end
            end
            llrs_pkg::K_HEART: begin
              out_valid_nxt = 1'b1;
              heard_nxt[n]  = 1'b1;
              avld_nxt[n]   = 1'b0;
              failed_nxt[n] = 1'b0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = llrs_pkg::ST_REJECT;
            end
          endcase
        end
      end

      llrs_pkg::BK_PSCAN, llrs_pkg::BK_TSCAN: begin
        issue = !issued_r;
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
          if (addr_r == LAST) begin
            issued_nxt = 1'b1;
            addr_nxt   = FIRST;
          end
        end
        if (pv_r && state_r == llrs_pkg::BK_PSCAN && !failed_r[pidx_r]) begin
          for (int k = 0; k < RP; k++) begin
            if (lt[k]) begin
              if (k == 0 || !lt[(k == 0) ? 0 : k - 1]) begin
                bh_nxt[k] = 1'b1;
                bi_nxt[k] = pidx_r;
                bv_nxt[k] = lval;
              end else begin
                bh_nxt[k] = bh_r[(k == 0) ? 0 : k - 1];
                bi_nxt[k] = bi_r[(k == 0) ? 0 : k - 1];
                bv_nxt[k] = bv_r[(k == 0) ? 0 : k - 1];
              end
            end
          end
        end
        if (pv_r && state_r == llrs_pkg::BK_TSCAN && heard_r[pidx_r]) begin
          awe              = 1'b1;
          avld_nxt[pidx_r] = 1'b1;
          if (nage > timeout_r) begin
            heard_nxt[pidx_r]  = 1'b0;
            failed_nxt[pidx_r] = 1'b1;
          end
        end
        if (issued_r && !pv_r) begin
          if (state_r == llrs_pkg::BK_TSCAN) begin
            state_nxt      = llrs_pkg::BK_IDLE;
            out_valid_nxt  = 1'b1;
            out_nxt.status = llrs_pkg::ST_OK;
          end else if (!bh_r[0]) begin
            state_nxt      = llrs_pkg::BK_IDLE;
            out_valid_nxt  = 1'b1;
            out_nxt.status = llrs_pkg::ST_NO_LIVE;
          end else begin
            state_nxt = llrs_pkg::BK_PINC;
            k_nxt     = '0;
          end
        end
      end

      llrs_pkg::BK_PINC: begin
        if (bh_r[k_r]) begin
          lwe              = 1'b1;
          lvld_nxt[lwaddr] = 1'b1;
        end
        if (k_r == KW'(RP - 1)) begin
          state_nxt              = llrs_pkg::BK_IDLE;
          out_valid_nxt          = 1'b1;
          out_nxt.status         = llrs_pkg::ST_OK;
          out_nxt.replica_first  = bh_r[0] ? llrs_pkg::NODE_W'(bi_r[0]) : '0;
          out_nxt.replica_second = bh_r[1] ? llrs_pkg::NODE_W'(bi_r[1]) : '0;
          out_nxt.replica_third  = bh_r[2] ? llrs_pkg::NODE_W'(bi_r[2]) : '0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      default: begin
        state_nxt = llrs_pkg::BK_IDLE;
      end
    endcase

    pv_nxt = issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llrs_pkg::BK_IDLE;
      failed_r    <= '0;
      heard_r     <= '0;
      lvld_r      <= '0;
      avld_r      <= '0;
      timeout_r   <= llrs_pkg::TIMEOUT_RESET;
      addr_r      <= FIRST;
      issued_r    <= 1'b0;
      pv_r        <= 1'b0;
      bh_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      failed_r    <= failed_nxt;
      heard_r     <= heard_nxt;
      lvld_r      <= lvld_nxt;
      avld_r      <= avld_nxt;
      addr_r      <= addr_nxt;
      issued_r    <= issued_nxt;
      pv_r        <= pv_nxt;
      bh_r        <= bh_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= addr_r;
    bi_r   <= bi_nxt;
    bv_r   <= bv_nxt;
    out_r  <= out_nxt;
  end

  // load count memory, entries read as zero until written (lvld)
  always_ff @(posedge clk) begin
    if (lwe) begin
      load_mem[lwaddr] <= lwdata;
    end
    load_rd_r <= load_mem[addr_r];
    lvq_r     <= lvld_r[addr_r];
  end

  // heartbeat age memory, entries read as zero until written (avld)
  always_ff @(posedge clk) begin
    if (awe) begin
      age_mem[awaddr] <= awdata;
    end
    age_rd_r <= age_mem[addr_r];
    avq_r    <= avld_r[addr_r];
  end

endmodule

### hw/rtl/least_loaded_replica_selector.sv
// ============================================================================
// least_loaded_replica_selector: least loaded replica placement with timeout
// Tracks load, failure and heartbeat age per storage node and places chunks
// on up to three live nodes with the lowest load.
//
//   channel  ports                          transfer
//   -------  -----------------------------  -----------------------------
//   input    start, busy, in_data           start && !busy
//   result   out_valid, out_data            out_valid (one cycle strobe)
//   config   cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// The back end applies failover, recover, heartbeat and rejects at dispatch;
// place runs dispatch, a scan of the load memory and one count write per
// replica; tick runs dispatch and a scan of the age memory. The back end
// takes a queued command once it is idle; the result strobe comes in the cycle after its last step.
// Reset is synchronous; node state reads as zero right after reset.
// busy is high while the two-entry queue is full; results cannot be stalled.
// ============================================================================
module least_loaded_replica_selector #(
  parameter int unsigned NODES = llrs_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  llrs_pkg::in_t               in_data,
  output logic                        out_valid,
  output llrs_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [llrs_pkg::CNT_W-1:0]  cfg_data
);

  logic           q_full, q_empty, q_push, q_pop;
  llrs_pkg::cmd_t q_din, q_head;

  assign cfg_ready = 1'b1;

  llrs_front #(
    .NODES (NODES)
  ) u_front (
    .start   (start),
    .in_data (in_data),
    .q_full  (q_full),
    .busy    (busy),
    .push    (q_push),
    .cmd     (q_din)
  );

  llrs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  llrs_back #(
    .NODES (NODES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### sim/least_loaded_replica_selector_test.sv
// ============================================================================
// least_loaded_replica_selector_test: self-checking bench for the selector
// Commands are queued by a sequencer and fed by a clocked driver with random
// gaps; every accepted command is run through an in-bench model of the node
// table, and each result strobe is compared with the oldest predicted reply.
// The timeout register is swept across phases, extremes included.
// ============================================================================
module least_loaded_replica_selector_test;

  localparam int unsigned NODES = llrs_pkg::NODES_DEF;
  localparam logic [2:0] OP_SPARE = 3'd5;
  localparam logic [2:0] OP_MAX = 3'd7;
  localparam int unsigned PHASE_CMDS = 165;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  llrs_pkg::in_t in_data = '0;
  logic cfg_valid = 1'b0;
  logic [llrs_pkg::CNT_W-1:0] cfg_data = '0;
  logic busy;
  logic out_valid;
  llrs_pkg::out_t out_data;
  logic cfg_ready;

  least_loaded_replica_selector #(
    .NODES(NODES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // node table model
  logic [llrs_pkg::CNT_W-1:0] node_load [NODES];
  logic                       node_failed [NODES];
  logic                       node_heard [NODES];
  logic [llrs_pkg::CNT_W-1:0] node_age [NODES];
  logic [llrs_pkg::CNT_W-1:0] timeout_now = llrs_pkg::TIMEOUT_RESET;

  llrs_pkg::in_t  cmd_backlog[$];
  llrs_pkg::out_t selector_replies[$];
  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cfg_writes = 0;
  int unsigned gap_left = 0;
  logic in_took = 1'b0;

  initial begin
    for (int i = 0; i < NODES; i++) begin
      node_load[i] = '0;
      node_failed[i] = 1'b0;
      node_heard[i] = 1'b0;
      node_age[i] = '0;
    end
  end

  function automatic bit node_valid(logic [llrs_pkg::NODE_W-1:0] n);
    return n != 0 && int'(n) < NODES;
  endfunction

  function automatic llrs_pkg::out_t run_selector_cmd(llrs_pkg::in_t cmd);
    llrs_pkg::out_t res;
    logic taken [NODES];
    logic [llrs_pkg::NODE_W-1:0] chosen [llrs_pkg::REPLICAS];
    int found;
    int best;
    bit have;
    logic [llrs_pkg::NODE_W-1:0] n;
    res = '0;
    res.status = llrs_pkg::ST_OK;
    n = cmd.node;
    found = 0;
    for (int i = 0; i < NODES; i++) taken[i] = 1'b0;
    case (cmd.opcode)
      llrs_pkg::OP_PLACE: begin
        for (int k = 0; k < llrs_pkg::REPLICAS; k++) begin
          have = 1'b0;
          best = 0;
          for (int i = 1; i < NODES; i++) begin
            if (!node_failed[i] && !taken[i] &&
                (!have || node_load[i] < node_load[best])) begin
              best = i;
              have = 1'b1;
            end
          end
          chosen[k] = '0;
          if (have) begin
            taken[best] = 1'b1;
            chosen[k] = best[llrs_pkg::NODE_W-1:0];
            found++;
          end
        end
        if (found == 0) begin
          res.status = llrs_pkg::ST_NO_LIVE;
        end else begin
          for (int k = 0; k < found; k++) begin
            if (node_load[chosen[k]] != llrs_pkg::SAT_VAL) node_load[chosen[k]]++;
          end
          res.replica_first = chosen[0];
          res.replica_second = chosen[1];
          res.replica_third = chosen[2];
        end
      end
      llrs_pkg::OP_FAILOVER: begin
        if (!node_valid(n) || node_failed[n]) begin
          res.status = llrs_pkg::ST_REJECT;
        end else begin
          node_failed[n] = 1'b1;
          node_load[n] = '0;
        end
      end
      llrs_pkg::OP_RECOVER: begin
        if (!node_valid(n) || !node_failed[n]) res.status = llrs_pkg::ST_REJECT;
        else node_failed[n] = 1'b0;
      end
      llrs_pkg::OP_HEARTBEAT: begin
        if (!node_valid(n)) begin
          res.status = llrs_pkg::ST_REJECT;
        end else begin
          node_heard[n] = 1'b1;
          node_age[n] = '0;
          node_failed[n] = 1'b0;
        end
      end
      llrs_pkg::OP_TICK: begin
        for (int i = 1; i < NODES; i++) begin
          if (node_heard[i]) begin
            if (node_age[i] != llrs_pkg::SAT_VAL) node_age[i]++;
            if (node_age[i] > timeout_now) begin
              node_heard[i] = 1'b0;
              node_failed[i] = 1'b1;
            end
          end
        end
      end
      default: res.status = llrs_pkg::ST_REJECT;
    endcase
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    logic next_start;
    llrs_pkg::in_t next_data;
    next_start = start;
    next_data = in_data;
    if (rst_n && (!start || in_took)) begin
      next_start = 1'b0;
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        next_data = cmd_backlog.pop_front();
        next_start = 1'b1;
        gap_left = $urandom_range(0, 9);
      end
    end
    start <= next_start;
    in_data <= next_data;
  end

  // input transfer capture
  always @(posedge clk) begin
    in_took <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      selector_replies.insert(selector_replies.size(), run_selector_cmd(in_data));
      accepted_count++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    llrs_pkg::out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (selector_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing pending: status %0d replicas %0d %0d %0d",
                   out_data.status, out_data.replica_first, out_data.replica_second,
                   out_data.replica_third);
      end else begin
        want = selector_replies.pop_front();
        if (out_data.status !== want.status ||
            out_data.replica_first !== want.replica_first ||
            out_data.replica_second !== want.replica_second ||
            out_data.replica_third !== want.replica_third) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result %0d: expected status %0d replicas %0d %0d %0d, ",
                      "got status %0d replicas %0d %0d %0d"},
                     results_seen, want.status, want.replica_first, want.replica_second,
                     want.replica_third, out_data.status, out_data.replica_first,
                     out_data.replica_second, out_data.replica_third);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on any channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic queue_cmd(input logic [2:0] op, input logic [llrs_pkg::NODE_W-1:0] n);
    llrs_pkg::in_t c;
    c.opcode = op;
    c.node = n;
    cmd_backlog.insert(cmd_backlog.size(), c);
    issued_count++;
  endtask

  task automatic queue_random_cmd();
    int unsigned pick;
    logic [2:0] op;
    logic [llrs_pkg::NODE_W-1:0] n;
    pick = $urandom_range(0, 99);
    n = llrs_pkg::NODE_W'($urandom_range(1, NODES - 1));
    if (pick < 35) op = llrs_pkg::OP_PLACE;
    else if (pick < 60) op = llrs_pkg::OP_HEARTBEAT;
    else if (pick < 80) op = llrs_pkg::OP_TICK;
    else if (pick < 88) op = llrs_pkg::OP_FAILOVER;
    else if (pick < 96) op = llrs_pkg::OP_RECOVER;
    else begin
      op = 3'($urandom_range(0, OP_MAX));
      n = llrs_pkg::NODE_W'($urandom_range(0, NODES - 1));
    end
    if (op == llrs_pkg::OP_PLACE || op == llrs_pkg::OP_TICK) begin
      n = llrs_pkg::NODE_W'($urandom);
    end
    queue_cmd(op, n);
  endtask

  task automatic drain_selector();
    while (accepted_count != issued_count || selector_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [llrs_pkg::CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    timeout_now = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [llrs_pkg::CNT_W-1:0] sweep [8];
    sweep[0] = 16'd3;
    sweep[1] = 16'hFFFF;
    sweep[2] = 16'd1;
    sweep[3] = 16'd0;
    sweep[4] = 16'd12;
    sweep[5] = llrs_pkg::CNT_W'($urandom_range(1, 16'hFFFF));
    sweep[6] = 16'd7;
    sweep[7] = 16'd30;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset timeout: single-node ops, rejects, unused opcodes
    queue_cmd(llrs_pkg::OP_PLACE, 4'd15);
    queue_cmd(llrs_pkg::OP_FAILOVER, 4'd0);
    queue_cmd(llrs_pkg::OP_FAILOVER, 4'd4);
    queue_cmd(llrs_pkg::OP_FAILOVER, 4'd4);
    queue_cmd(llrs_pkg::OP_RECOVER, 4'd4);
    queue_cmd(llrs_pkg::OP_RECOVER, 4'd4);
    queue_cmd(llrs_pkg::OP_HEARTBEAT, 4'd0);
    queue_cmd(llrs_pkg::OP_TICK, 4'd15);
    queue_cmd(OP_SPARE, 4'd10);
    queue_cmd(OP_MAX, 4'd15);
    queue_cmd(llrs_pkg::OP_PLACE, 4'd0);
    drain_selector();

    // zero timeout: every heard node fails on the first tick
    write_timeout('0);
    for (int i = 1; i < NODES; i++) begin
      queue_cmd(llrs_pkg::OP_HEARTBEAT, i[llrs_pkg::NODE_W-1:0]);
    end
    queue_cmd(llrs_pkg::OP_TICK, 4'd0);
    queue_cmd(llrs_pkg::OP_PLACE, 4'd0);
    queue_cmd(llrs_pkg::OP_RECOVER, 4'd2);
    queue_cmd(llrs_pkg::OP_PLACE, 4'd0);
    queue_cmd(llrs_pkg::OP_RECOVER, 4'd0);
    queue_cmd(llrs_pkg::OP_HEARTBEAT, 4'd7);
    queue_cmd(llrs_pkg::OP_PLACE, 4'd0);
    drain_selector();

    for (int p = 0; p < 8; p++) begin
      write_timeout(sweep[p]);
      for (int k = 0; k < PHASE_CMDS; k++) queue_random_cmd();
      drain_selector();
    end

    $display("Ran %0d commands over %0d timeout settings; %0d results checked.",
             accepted_count, cfg_writes + 1, results_seen);
    $display("Covered placement, failover, recovery, heartbeat aging and rejects.");
    if (mismatches == 0 && selector_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
